// File: rtl/core/lru_pkg.sv
// Shared types and fixed widths for the LRU cache lookup block.
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

    localparam int KEY_W       = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int CAP_W       = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd2;

    // Per-cell status seen by the chain controller
    typedef struct packed {
        logic valid;
        logic match;
    } lru_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lru_cache_lookup.sv
// Top level of the LRU cache lookup: recency-ordered cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative LRU cache built as a chain of cells kept in recency order:
// cell 0 holds the most recent entry and valid cells always fill the chain from
// the front. Each request is looked up against every cell in the cycle it is
// accepted; the chain then shifts by one place up to the hit cell (hit), up to
// the last valid cell (insert with eviction) or one past it (plain insert), and
// the request's entry lands in cell 0. One request is taken per clock while
// results are taken; key compare and chain shift both act on acceptance.
// The result sits in an output register, so a new request is taken while a
// result waits as long as that result is taken in the same cycle. Write the
// capacity only while idle; 0 acts as 1 and values above MAX_ENTRIES act as
// MAX_ENTRIES. No clearing pass follows reset.
module lru_cache_lookup #(
    parameter int MAX_ENTRIES = 8,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [lru_pkg::CAP_W-1:0]       cfg_capacity,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [lru_pkg::KEY_W-1:0]       s_key,
    input  wire logic                                   s_fill_present,
    input  wire logic        [lru_pkg::OUT_VALUE_W-1:0] s_fill_value,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_hit,
    output logic                                        m_found,
    output logic             [lru_pkg::OUT_VALUE_W-1:0] m_value,
    output logic                                        m_evicted,
    output logic signed      [lru_pkg::KEY_W-1:0]       m_evicted_key
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [lru_pkg::CAP_W-1:0]  cap_reg;
    logic [CW-1:0]              cap_eff;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    lru_pkg::lru_stat_t         stat [MAX_ENTRIES];
    logic [lru_pkg::KEY_W-1:0]  cell_key [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]      cell_val [MAX_ENTRIES];
    logic                       d_valid_w [MAX_ENTRIES];
    logic [lru_pkg::KEY_W-1:0]  d_key_w [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]      d_val_w [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0]     valid_vec;
    logic [MAX_ENTRIES-1:0]     match_vec;
    logic [MAX_ENTRIES-1:0]     last_vec;
    logic [MAX_ENTRIES-1:0]     ins_span;
    logic [MAX_ENTRIES-1:0]     upto_hit;
    logic [MAX_ENTRIES-1:0]     load_vec;

    logic                       accept;
    logic                       hit_any;
    logic                       evict;
    logic                       insert;
    logic [VALUE_BITS-1:0]      hit_value;
    logic [VALUE_BITS-1:0]      fill_st;
    logic [VALUE_BITS-1:0]      head_value;
    logic [lru_pkg::KEY_W-1:0]  evict_key;
    logic [63:0]                fill_wide;
    logic [63:0]                head_wide;

    logic                             m_valid_reg;
    logic                             m_hit_reg;
    logic                             m_found_reg;
    logic [lru_pkg::OUT_VALUE_W-1:0]  m_value_reg;
    logic                             m_evicted_reg;
    logic [lru_pkg::KEY_W-1:0]        m_evicted_key_reg;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lru_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_capacity;
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (32'(cap_reg) > 32'(MAX_ENTRIES)) begin
            cap_eff = CW'(MAX_ENTRIES);
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    // Cell chain
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign d_valid_w[g] = 1'b1;
            assign d_key_w[g]   = s_key;
            assign d_val_w[g]   = head_value;
        end else begin : g_link
            assign d_valid_w[g] = stat[g-1].valid;
            assign d_key_w[g]   = cell_key[g-1];
            assign d_val_w[g]   = cell_val[g-1];
        end

        lru_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (load_vec[g]),
            .d_valid   (d_valid_w[g]),
            .d_key     (d_key_w[g]),
            .d_value   (d_val_w[g]),
            .probe_key (s_key),
            .stat      (stat[g]),
            .q_key     (cell_key[g]),
            .q_value   (cell_val[g])
        );

        assign valid_vec[g] = stat[g].valid;
        assign match_vec[g] = stat[g].match;
    end

    // Lookup
    assign accept    = s_valid && s_ready;
    assign hit_any   = |match_vec;
    assign last_vec  = valid_vec & ~(valid_vec >> 1);
    assign ins_span  = (valid_vec << 1) | MAX_ENTRIES'(1);
    assign evict     = (count_reg >= cap_eff) || (count_reg == CW'(MAX_ENTRIES));
    assign insert    = !hit_any && s_fill_present;

    assign fill_wide  = {32'b0, s_fill_value};
    assign fill_st    = fill_wide[VALUE_BITS-1:0];
    assign head_value = hit_any ? hit_value : fill_st;
    assign head_wide  = 64'(head_value);

    always_comb begin
        logic seen;
        hit_value = '0;
        evict_key = '0;
        seen      = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_value = hit_value | cell_val[i];
            end
            if (last_vec[i]) begin
                evict_key = evict_key | cell_key[i];
            end
        end
        // cells at or in front of the hit cell move
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            seen        = seen | match_vec[i];
            upto_hit[i] = seen;
        end
    end

    always_comb begin
        load_vec = '0;
        if (accept) begin
            if (hit_any) begin
                load_vec = upto_hit;
            end else if (s_fill_present) begin
                load_vec = evict ? valid_vec : ins_span;
            end
        end
    end

    assign count_next = (accept && insert && !evict) ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register
    assign s_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_hit_reg         <= hit_any;
            m_found_reg       <= hit_any || s_fill_present;
            m_value_reg       <= (hit_any || s_fill_present) ?
                                 head_wide[lru_pkg::OUT_VALUE_W-1:0] : '0;
            m_evicted_reg     <= insert && evict;
            m_evicted_key_reg <= (insert && evict) ? evict_key : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_found       = m_found_reg;
    assign m_value       = m_value_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evicted_key_reg;

    // Checks
    a_count_tracks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(valid_vec)))
        else $error("occupancy count out of step with valid cells");

    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
        else $error("valid cells not packed at the front of the chain");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("key held in more than one cell");

    a_hit_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && hit_any |=> $stable(count_reg))
        else $error("hit changed occupancy");

    a_evict_is_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_evicted_reg |-> m_found_reg && !m_hit_reg)
        else $error("eviction reported on a beat that was not an insert");

endmodule

`default_nettype wire

// File: rtl/core/lru_cell.sv
// One entry of the recency-ordered chain: holds key and value, compares the probe key.
`timescale 1ns / 1ps
`default_nettype none

module lru_cell #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic                          d_valid,
    input  wire logic [lru_pkg::KEY_W-1:0]     d_key,
    input  wire logic [VALUE_BITS-1:0]         d_value,
    input  wire logic [lru_pkg::KEY_W-1:0]     probe_key,
    output lru_pkg::lru_stat_t                 stat,
    output logic      [lru_pkg::KEY_W-1:0]     q_key,
    output logic      [VALUE_BITS-1:0]         q_value
);

    logic                        valid_reg;
    logic [lru_pkg::KEY_W-1:0]   key_reg;
    logic [VALUE_BITS-1:0]       value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg   <= d_key;
            value_reg <= d_value;
        end
    end

    assign stat.valid = valid_reg;
    assign stat.match = valid_reg && (key_reg == probe_key);
    assign q_key      = key_reg;
    assign q_value    = value_reg;

endmodule

`default_nettype wire
